[rtl/tmmex_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the toggle multiset mex tracker
// no dependencies; used by tmmex_store and toggle_multiset_mex_tracker_top
package tmmex_pkg;

    localparam int CNT_W = 17;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam int OUT_W = 17;

    localparam logic ACT_TOGGLE = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_T_MUL,
        S_T_RD,
        S_T_WR,
        S_Q_BRD,
        S_Q_BCHK,
        S_Q_VRD,
        S_Q_VCHK
    } t_state;

    // write strobes for the three stores
    typedef struct packed {
        logic pres;
        logic cnt;
        logic fill;
    } t_wr_en;

endpackage

[rtl/tmmex_store.sv]
`timescale 1ns / 1ps
// presence bits, value counts and block tallies, each one write and one registered read port
// depends on tmmex_pkg
module tmmex_store
    import tmmex_pkg::*;
#(
    parameter int ELEMENTS    = 65536,
    parameter int VALUE_LIMIT = 65536,
    parameter int NB          = 256,
    parameter int EIW         = 16,
    parameter int VIW         = 16,
    parameter int BIW         = 8,
    parameter int FW          = 9
) (
    input  logic             i_clk,
    input  t_wr_en           i_we,
    input  logic [EIW-1:0]   i_pres_addr,
    input  logic             i_pres_wd,
    input  logic [VIW-1:0]   i_cnt_waddr,
    input  logic [VIW-1:0]   i_cnt_raddr,
    input  logic [CNT_W-1:0] i_cnt_wd,
    input  logic [BIW-1:0]   i_fill_waddr,
    input  logic [BIW-1:0]   i_fill_raddr,
    input  logic [FW-1:0]    i_fill_wd,
    output logic             o_pres_q,
    output logic [CNT_W-1:0] o_cnt_q,
    output logic [FW-1:0]    o_fill_q
);

    logic             pres_mem [ELEMENTS];
    logic [CNT_W-1:0] cnt_mem  [VALUE_LIMIT];
    logic [FW-1:0]    fill_mem [NB];

    always_ff @(posedge i_clk) begin
        if (i_we.pres) begin
            pres_mem[i_pres_addr] <= i_pres_wd;
        end
        o_pres_q <= pres_mem[i_pres_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.cnt) begin
            cnt_mem[i_cnt_waddr] <= i_cnt_wd;
        end
        o_cnt_q <= cnt_mem[i_cnt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_we.fill) begin
            fill_mem[i_fill_waddr] <= i_fill_wd;
        end
        o_fill_q <= fill_mem[i_fill_raddr];
    end

endmodule

[rtl/toggle_multiset_mex_tracker_top.sv]
`timescale 1ns / 1ps
// multiset of element values with mex queries over per-block tallies
// depends on tmmex_pkg and tmmex_store
//
// channel   dir  tdata (low bit up)                               tuser
// s_axis    in   element_index[15:0], element_value[47:16]        action (0 toggle, 1 query)
// m_axis    out  mex_value[16:0], zero pad to 24 bits             -
//
// a toggle passes through accept, block index multiply, tally read and write back;
// one whose index or value is out of range is dropped at accept
// a query reads block tallies up to the first block not full,
// then reads the values in that block up to the first with a zero count
// after reset a clearing pass over max(ELEMENTS, VALUE_LIMIT) entries runs, input not ready
// a finished result waits in an output register; the next query stalls only on its own result
module toggle_multiset_mex_tracker_top
    import tmmex_pkg::*;
#(
    parameter int ELEMENTS    = 65536,
    parameter int VALUE_LIMIT = 65536,
    parameter int BLOCK       = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // element_index[15:0], element_value[47:16]
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // mex_value[16:0], zero pad
);

    localparam int EIW       = $clog2(ELEMENTS);
    localparam int VIW       = $clog2(VALUE_LIMIT);
    localparam int NB        = (VALUE_LIMIT + BLOCK - 1) / BLOCK;
    localparam int BIW       = (NB > 1) ? $clog2(NB) : 1;
    localparam int FW        = $clog2(BLOCK + 1);
    localparam int LAST_SIZE = VALUE_LIMIT - (NB - 1) * BLOCK;
    localparam int DL        = $clog2(BLOCK);
    localparam int DK        = VIW + DL;
    localparam int MW        = VIW + 2;
    localparam int PW        = VIW + MW;
    localparam longint unsigned DMUL = ((longint'(1) << DK) + BLOCK - 1) / BLOCK;
    localparam int CLR_N     = (ELEMENTS > VALUE_LIMIT) ? ELEMENTS : VALUE_LIMIT;
    localparam int CLW       = $clog2(CLR_N + 1);

    t_state           r_state, n_state;
    logic [CLW-1:0]   r_clr, n_clr;
    logic [EIW-1:0]   r_idx, n_idx;
    logic [VIW-1:0]   r_val, n_val;
    logic [BIW-1:0]   r_bidx, n_bidx;
    logic [BIW-1:0]   r_blk, n_blk;
    logic [VIW-1:0]   r_base, n_base;
    logic [VIW-1:0]   r_vidx, n_vidx;
    logic             r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_mex, n_mex;

    t_wr_en           w_we;
    logic [EIW-1:0]   w_pres_addr;
    logic             w_pres_wd;
    logic [VIW-1:0]   w_cnt_waddr;
    logic [VIW-1:0]   w_cnt_raddr;
    logic [CNT_W-1:0] w_cnt_wd;
    logic [BIW-1:0]   w_fill_waddr;
    logic [BIW-1:0]   w_fill_raddr;
    logic [FW-1:0]    w_fill_wd;
    logic             w_pres_q;
    logic [CNT_W-1:0] w_cnt_q;
    logic [FW-1:0]    w_fill_q;

    logic [31:0]      w_idx32;
    logic [31:0]      w_val32;
    logic [31:0]      w_vidx32;
    logic [31:0]      w_lim32;
    logic [PW-1:0]    w_prod;
    logic [FW-1:0]    w_bsize;
    logic             w_out_free;
    logic             w_in_range;

    assign w_idx32    = {16'd0, s_axis_tdata[15:0]};
    assign w_val32    = s_axis_tdata[47:16];
    assign w_vidx32   = 32'(r_vidx);
    assign w_lim32    = 32'(VALUE_LIMIT);
    assign w_in_range = (w_idx32 < 32'(ELEMENTS)) && (w_val32 < 32'(VALUE_LIMIT));
    // block index by reciprocal multiply, exact for every value below the limit
    assign w_prod     = PW'(r_val) * PW'(DMUL);
    assign w_bsize    = (r_blk == BIW'(NB - 1)) ? FW'(LAST_SIZE) : FW'(BLOCK);
    assign w_out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(24 - OUT_W){1'b0}}, r_mex};

    tmmex_store #(
        .ELEMENTS    (ELEMENTS),
        .VALUE_LIMIT (VALUE_LIMIT),
        .NB          (NB),
        .EIW         (EIW),
        .VIW         (VIW),
        .BIW         (BIW),
        .FW          (FW)
    ) u_store (
        .i_clk        (i_clk),
        .i_we         (w_we),
        .i_pres_addr  (w_pres_addr),
        .i_pres_wd    (w_pres_wd),
        .i_cnt_waddr  (w_cnt_waddr),
        .i_cnt_raddr  (w_cnt_raddr),
        .i_cnt_wd     (w_cnt_wd),
        .i_fill_waddr (w_fill_waddr),
        .i_fill_raddr (w_fill_raddr),
        .i_fill_wd    (w_fill_wd),
        .o_pres_q     (w_pres_q),
        .o_cnt_q      (w_cnt_q),
        .o_fill_q     (w_fill_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_val  <= n_val;
        r_bidx <= n_bidx;
        r_blk  <= n_blk;
        r_base <= n_base;
        r_vidx <= n_vidx;
        r_mex  <= n_mex;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_idx       = r_idx;
        n_val       = r_val;
        n_bidx      = r_bidx;
        n_blk       = r_blk;
        n_base      = r_base;
        n_vidx      = r_vidx;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_mex       = r_mex;

        w_we         = '0;
        w_pres_addr  = r_idx;
        w_pres_wd    = !w_pres_q;
        w_cnt_waddr  = r_val;
        w_cnt_raddr  = r_val;
        w_cnt_wd     = w_cnt_q;
        w_fill_waddr = r_bidx;
        w_fill_raddr = r_bidx;
        w_fill_wd    = w_fill_q;

        unique case (r_state)
            S_CLR: begin
                // sweep every store to zero, one entry a cycle
                w_pres_addr  = EIW'(r_clr);
                w_cnt_waddr  = VIW'(r_clr);
                w_fill_waddr = BIW'(r_clr);
                w_pres_wd    = 1'b0;
                w_cnt_wd     = '0;
                w_fill_wd    = '0;
                w_we.pres    = (r_clr < CLW'(ELEMENTS));
                w_we.cnt     = (r_clr < CLW'(VALUE_LIMIT));
                w_we.fill    = (r_clr < CLW'(NB));
                n_clr        = r_clr + 1'b1;
                if (r_clr == CLW'(CLR_N - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_idx = w_idx32[EIW-1:0];
                    n_val = w_val32[VIW-1:0];
                    if (s_axis_tuser == ACT_QUERY) begin
                        n_blk   = '0;
                        n_base  = '0;
                        n_state = S_Q_BRD;
                    end else if (w_in_range) begin
                        n_state = S_T_MUL;
                    end
                end
            end
            S_T_MUL: begin
                n_bidx  = BIW'(w_prod >> DK);
                n_state = S_T_RD;
            end
            S_T_RD: begin
                n_state = S_T_WR;
            end
            S_T_WR: begin
                w_we.pres = 1'b1;
                w_we.cnt  = 1'b1;
                if (!w_pres_q) begin
                    if (w_cnt_q != CNT_MAX) begin
                        w_cnt_wd = w_cnt_q + 1'b1;
                    end
                    w_we.fill = (w_cnt_q == '0);
                    w_fill_wd = w_fill_q + 1'b1;
                end else begin
                    // underflow guard: a zero count stays zero
                    if (w_cnt_q != '0) begin
                        w_cnt_wd = w_cnt_q - 1'b1;
                    end
                    w_we.fill = (w_cnt_q == CNT_W'(1));
                    w_fill_wd = w_fill_q - 1'b1;
                end
                n_state = S_IDLE;
            end
            S_Q_BRD: begin
                w_fill_raddr = r_blk;
                n_state      = S_Q_BCHK;
            end
            S_Q_BCHK: begin
                w_fill_raddr = r_blk;
                if (w_fill_q < w_bsize) begin
                    n_vidx  = r_base;
                    n_state = S_Q_VRD;
                end else if (r_blk == BIW'(NB - 1)) begin
                    // every value present
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_mex       = w_lim32[OUT_W-1:0];
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_blk   = r_blk + 1'b1;
                    n_base  = r_base + VIW'(BLOCK);
                    n_state = S_Q_BRD;
                end
            end
            S_Q_VRD: begin
                w_cnt_raddr = r_vidx;
                n_state     = S_Q_VCHK;
            end
            S_Q_VCHK: begin
                w_cnt_raddr = r_vidx;
                if (w_cnt_q == '0) begin
                    if (w_out_free) begin
                        n_out_valid = 1'b1;
                        n_mex       = w_vidx32[OUT_W-1:0];
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_vidx  = r_vidx + 1'b1;
                    n_state = S_Q_VRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
